### hw/rtl/cel_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cel_pkg
// Shared types and constants of the cross-entropy loss and gradient block.
// ---------------------------------------------------------------------------
package cel_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int VAL_W       = 25;
  localparam int GRAD_W      = 26;
  localparam int LOSS_W      = 38;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int CC_W        = 11;
  localparam int RC_W        = 17;

  localparam int DEF_MAX_CLASSES = 1024;
  localparam int DEF_MAX_ROWS    = 65536;

  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMIT_GRAD   = 2'd2;

  localparam logic [CC_W-1:0] CLASS_COUNT_RST = 11'd10;
  localparam logic [RC_W-1:0] ROW_COUNT_RST   = 17'd1;

  localparam longint ONE_FIX  = 64'd1 << FRAC_BITS;
  localparam longint EPS_RAW  = (ONE_FIX + 64'd500000) / 64'd1000000;
  localparam logic [VAL_W-1:0] EPS_VAL = (EPS_RAW == 0) ? VAL_W'(1) : VAL_W'(EPS_RAW);
  localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(ONE_FIX);

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

  typedef struct packed {
    logic [VAL_W-1:0]         q;
    logic [VAL_W-1:0]         label;
    logic signed [GRAD_W-1:0] gradient;
    logic                     gradient_valid;
    logic                     row_end;
    logic                     batch_end;
    logic                     emits;
  } ent_t;

endpackage

### hw/rtl/cel_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cel_if
// Channel interfaces: input elements, results and register writes.
// ---------------------------------------------------------------------------
interface cel_in_if;
  logic                     valid;
  logic                     ready;
  logic [cel_pkg::VAL_W-1:0] probability;
  logic [cel_pkg::VAL_W-1:0] label;
  modport source (output valid, output probability, output label, input ready);
  modport sink   (input valid, input probability, input label, output ready);
endinterface

interface cel_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cel_pkg::GRAD_W-1:0] gradient;
  logic                             gradient_valid;
  logic [cel_pkg::LOSS_W-1:0]        row_loss;
  logic                             loss_valid;
  logic                             batch_done;
  modport source (output valid, output gradient, output gradient_valid, output row_loss,
                  output loss_valid, output batch_done, input ready);
  modport sink   (input valid, input gradient, input gradient_valid, input row_loss,
                  input loss_valid, input batch_done, output ready);
endinterface

interface cel_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cel_pkg::CFG_IDX_W-1:0]  index;
  logic [cel_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/cel_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cel_front
// Register file, row/batch position tracking and element classification.
// ---------------------------------------------------------------------------
module cel_front #(
  parameter int MAX_CLASSES = cel_pkg::DEF_MAX_CLASSES,
  parameter int MAX_ROWS    = cel_pkg::DEF_MAX_ROWS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cel_pkg::VAL_W-1:0]     in_probability,
  input  logic [cel_pkg::VAL_W-1:0]     in_label,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cel_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                         push_valid,
  input  logic                         push_ready,
  output cel_pkg::ent_t                push_ent
);
  import cel_pkg::*;

  localparam int CPW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int RPW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = CPW + 1;
  localparam int RW  = RPW + 1;

  logic [CC_W-1:0] class_count_r;
  logic [RC_W-1:0] row_count_r;
  logic            emit_grad_r;
  logic [CPW-1:0]  cpos_r, cpos_nxt;
  logic [RPW-1:0]  rpos_r, rpos_nxt;
  logic [CW-1:0]   cc;
  logic [RW-1:0]   rc;
  logic            row_end, batch_end, take;
  logic [VAL_W-1:0] q;

  always_comb begin
    if (class_count_r == '0) cc = CW'(1);
    else if (32'(class_count_r) > 32'(MAX_CLASSES)) cc = CW'(MAX_CLASSES);
    else cc = CW'(class_count_r);
    if (row_count_r == '0) rc = RW'(1);
    else if (32'(row_count_r) > 32'(MAX_ROWS)) rc = RW'(MAX_ROWS);
    else rc = RW'(row_count_r);
  end

  assign row_end   = ({1'b0, cpos_r} + CW'(1)) >= cc;
  assign batch_end = row_end && (({1'b0, rpos_r} + RW'(1)) >= rc);

  always_comb begin
    q = (in_probability == '0) ? EPS_VAL : in_probability;
    if (q > ONE_VAL) q = ONE_VAL;
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid && push_ready;
  assign cfg_ready  = 1'b1;

  always_comb begin
    push_ent.q              = q;
    push_ent.label          = in_label;
    push_ent.gradient       = emit_grad_r
                            ? ($signed({1'b0, in_probability}) - $signed({1'b0, in_label}))
                            : '0;
    push_ent.gradient_valid = emit_grad_r;
    push_ent.row_end        = row_end;
    push_ent.batch_end      = batch_end;
    push_ent.emits          = emit_grad_r || row_end;
  end

  always_comb begin
    cpos_nxt = cpos_r;
    rpos_nxt = rpos_r;
    if (take) begin
      if (row_end) begin
        cpos_nxt = '0;
        rpos_nxt = batch_end ? '0 : rpos_r + RPW'(1);
      end else begin
        cpos_nxt = cpos_r + CPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= CLASS_COUNT_RST;
      row_count_r   <= ROW_COUNT_RST;
      emit_grad_r   <= 1'b1;
      cpos_r        <= '0;
      rpos_r        <= '0;
    end else begin
      cpos_r <= cpos_nxt;
      rpos_r <= rpos_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_CLASS_COUNT: class_count_r <= cfg_data[CC_W-1:0];
          REG_ROW_COUNT:   row_count_r   <= cfg_data[RC_W-1:0];
          REG_EMIT_GRAD:   emit_grad_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

### hw/rtl/cel_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cel_queue
// Two-entry queue between classification and loss evaluation.
// ---------------------------------------------------------------------------
module cel_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  cel_pkg::ent_t push_ent,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cel_pkg::ent_t pop_ent
);
  import cel_pkg::*;

  ent_t       slot0_r, slot1_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_ent    = slot0_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      if (do_push && cnt_r == 2'd1) slot0_r <= push_ent;
      else slot0_r <= slot1_r;
    end else if (do_push) begin
      if (cnt_r == 2'd0) slot0_r <= push_ent;
      else slot1_r <= push_ent;
    end
  end

endmodule

### hw/rtl/cel_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cel_back
// Log evaluation, loss accumulation and result register.
// ---------------------------------------------------------------------------
module cel_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  cel_pkg::ent_t                      pop_ent,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cel_pkg::GRAD_W-1:0]  out_gradient,
  output logic                               out_gradient_valid,
  output logic [cel_pkg::LOSS_W-1:0]         out_row_loss,
  output logic                               out_loss_valid,
  output logic                               out_batch_done
);
  import cel_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_SQR  = 4'd2;
  localparam logic [3:0] S_PREP = 4'd3;
  localparam logic [3:0] S_ML0  = 4'd4;
  localparam logic [3:0] S_ML1  = 4'd5;
  localparam logic [3:0] S_RND  = 4'd6;
  localparam logic [3:0] S_MT0  = 4'd7;
  localparam logic [3:0] S_MT1  = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;

  logic [3:0]        st_r;
  ent_t              ent_r;
  logic [30:0]       m_r;
  logic [4:0]        k_r;
  logic [4:0]        cnt_r;
  logic [27:0]       frac_r;
  logic [32:0]       nl2_r;
  logic [63:0]       acc_r;
  logic [36:0]       nl_r;
  logic [LOSS_W-1:0] loss_r;
  logic              ov_r;

  logic [61:0]       sq;
  logic [31:0]       sq_hi;
  logic [30:0]       term;
  logic [LOSS_W:0]   sum;
  logic [LOSS_W-1:0] sat;
  logic              out_free;

  assign sq       = 62'(m_r) * 62'(m_r);
  assign sq_hi    = sq[61:30];
  assign term     = 31'((acc_r + (64'd1 << 31)) >> 32);
  assign sum      = {1'b0, loss_r} + (LOSS_W+1)'(term);
  assign sat      = sum[LOSS_W] ? LOSS_MAX : sum[LOSS_W-1:0];
  assign out_free = !ov_r || out_ready;
  assign pop_ready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      loss_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (ov_r && out_ready && !(st_r == S_ACC && ent_r.emits)) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (pop_valid) begin
            ent_r <= pop_ent;
            m_r   <= {pop_ent.q, 6'b0};
            k_r   <= 5'(FRAC_BITS);
            st_r  <= S_NORM;
          end
        end
        S_NORM: begin
          if (m_r[30]) begin
            cnt_r  <= '0;
            frac_r <= '0;
            st_r   <= S_SQR;
          end else begin
            m_r <= {m_r[29:0], 1'b0};
            k_r <= k_r - 5'd1;
          end
        end
        S_SQR: begin
          if (sq_hi[31]) begin
            m_r    <= sq_hi[31:1];
            frac_r <= {frac_r[26:0], 1'b1};
          end else begin
            m_r    <= sq_hi[30:0];
            frac_r <= {frac_r[26:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd27) st_r <= S_PREP;
        end
        S_PREP: begin
          nl2_r <= ({28'(5'(FRAC_BITS) - k_r), 5'b0} << 23) - 33'(frac_r);
          st_r  <= S_ML0;
        end
        S_ML0: begin
          acc_r <= 64'(nl2_r[16:0]) * 64'(LN2_Q30);
          st_r  <= S_ML1;
        end
        S_ML1: begin
          acc_r <= acc_r + ((64'(nl2_r[32:17]) * 64'(LN2_Q30)) << 17);
          st_r  <= S_RND;
        end
        S_RND: begin
          nl_r <= 37'((acc_r + 64'(1 << 25)) >> 26);
          st_r <= S_MT0;
        end
        S_MT0: begin
          acc_r <= 64'(ent_r.label) * 64'(nl_r[18:0]);
          st_r  <= S_MT1;
        end
        S_MT1: begin
          acc_r <= acc_r + ((64'(ent_r.label) * 64'(nl_r[36:19])) << 19);
          st_r  <= S_ACC;
        end
        S_ACC: begin
          if (out_free) begin
            loss_r <= ent_r.row_end ? '0 : sat;
            if (ent_r.emits) begin
              ov_r               <= 1'b1;
              out_gradient       <= ent_r.gradient;
              out_gradient_valid <= ent_r.gradient_valid;
              out_row_loss       <= ent_r.row_end ? sat : '0;
              out_loss_valid     <= ent_r.row_end;
              out_batch_done     <= ent_r.batch_end;
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;

endmodule

### hw/rtl/cross_entropy_loss_and_grad.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cross_entropy_loss_and_grad
// Streaming softmax cross-entropy loss and gradient, one class element a beat.
//
// Usage: write class_count (index 0), row_count (index 1) and emit_gradients
// (index 2) on cfg_ch while idle; cfg_ch is always ready. Stream elements
// row-major on in_ch as probability/label beats. out_ch gives one beat per
// element when gradients are on, otherwise one beat per row end; row_loss and
// loss_valid ride on the row's last element, batch_done on the batch's last.
// Engine: an element leaving the queue has the leading zeros (0..24) of its
// clamped probability shifted out, then 28 truncating squarings on the
// 31x31 squaring multiplier give its negative base-2 log, which is scaled by
// ln 2 and by the label and added to the row's loss sum. The engine takes the
// next element only once it is idle again. A two-entry queue lets in_ch
// take up to two beats ahead of the engine.
// Reset: registers return to class_count 10, row_count 1, gradients on;
// positions and the loss sum clear, queue and result register empty.
// Stall: the result register holds while out_ch.ready is low; the engine
// holds its finished element until the register frees, while the queue fills.
// ---------------------------------------------------------------------------
module cross_entropy_loss_and_grad #(
  parameter int MAX_CLASSES = cel_pkg::DEF_MAX_CLASSES,
  parameter int MAX_ROWS    = cel_pkg::DEF_MAX_ROWS
) (
  input  logic      clk,
  input  logic      rst_n,
  cel_in_if.sink    in_ch,
  cel_out_if.source out_ch,
  cel_cfg_if.sink   cfg_ch
);
  import cel_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  ent_t push_ent, pop_ent;

  cel_front #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_probability(in_ch.probability),
    .in_label      (in_ch.label),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_ent      (push_ent)
  );

  cel_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_ent  (push_ent),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_ent   (pop_ent)
  );

  cel_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_ent           (pop_ent),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_gradient      (out_ch.gradient),
    .out_gradient_valid(out_ch.gradient_valid),
    .out_row_loss      (out_ch.row_loss),
    .out_loss_valid    (out_ch.loss_valid),
    .out_batch_done    (out_ch.batch_done)
  );

endmodule

### hw/rtl/cel_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cel_checker
// Port-level checks on the result channel of the loss block.
// ---------------------------------------------------------------------------
module cel_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [cel_pkg::GRAD_W-1:0] out_gradient,
  input logic                              out_gradient_valid,
  input logic [cel_pkg::LOSS_W-1:0]        out_row_loss,
  input logic                              out_loss_valid,
  input logic                              out_batch_done
);
  import cel_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_loss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_loss_valid |-> out_row_loss == '0)
    else $error("row loss nonzero off a row end");

  a_grad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_gradient_valid |-> out_gradient == '0)
    else $error("gradient nonzero while disabled");

  a_batch_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_batch_done |-> out_loss_valid)
    else $error("batch end without row end");

  a_beat_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gradient_valid || out_loss_valid)
    else $error("empty result beat");

endmodule

bind cross_entropy_loss_and_grad cel_checker u_cel_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_gradient      (out_ch.gradient),
  .out_gradient_valid(out_ch.gradient_valid),
  .out_row_loss      (out_ch.row_loss),
  .out_loss_valid    (out_ch.loss_valid),
  .out_batch_done    (out_ch.batch_done)
);

### sim/cross_entropy_loss_and_grad_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cross_entropy_loss_and_grad_checker
// Watches the element, result and register channels of the cross-entropy
// block, predicts each result beat and compares it field by field.
// ---------------------------------------------------------------------------
module cross_entropy_loss_and_grad_checker (
  input  logic clk,
  input  logic rst_n,
  cel_in_if    in_ch,
  cel_out_if   out_ch,
  cel_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending_results
);
  import cel_pkg::*;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic                     gradient_valid;
    logic [LOSS_W-1:0]        row_loss;
    logic                     loss_valid;
    logic                     batch_done;
  } ce_result_t;

  ce_result_t      loss_grad_q[$];
  logic [CC_W-1:0] class_cfg;
  logic [RC_W-1:0] row_cfg;
  logic            grad_on;
  int unsigned     class_pos;
  int unsigned     row_pos;
  logic [63:0]     loss_sum;

  function automatic logic [63:0] neg_ln_fix(logic [63:0] q);
    int unsigned k;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] nl2;
    k = 0;
    frac = 0;
    while (k < 62 && (q >> (k + 1)) != 0) k++;
    m = q << (30 - k);
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    nl2 = (64'(FRAC_BITS - int'(k)) << 28) - frac;
    return (nl2 * 64'(LN2_Q30) + (64'd1 << 25)) >> 26;
  endfunction

  task automatic predict_element(logic [VAL_W-1:0] prob, logic [VAL_W-1:0] lab);
    int unsigned cc;
    int unsigned rc;
    logic [63:0] q;
    logic [63:0] term;
    logic        row_end;
    logic        batch_end;
    ce_result_t  r;
    cc = class_cfg;
    rc = row_cfg;
    if (cc < 1) cc = 1;
    if (cc > DEF_MAX_CLASSES) cc = DEF_MAX_CLASSES;
    if (rc < 1) rc = 1;
    if (rc > DEF_MAX_ROWS) rc = DEF_MAX_ROWS;
    q = (prob == 0) ? 64'(EPS_VAL) : 64'(prob);
    if (q > ONE_FIX) q = ONE_FIX;
    term = (64'(lab) * neg_ln_fix(q) + (64'd1 << 31)) >> 32;
    loss_sum = loss_sum + term;
    if (loss_sum > 64'(LOSS_MAX)) loss_sum = 64'(LOSS_MAX);
    row_end = (class_pos + 1) >= cc;
    batch_end = row_end && ((row_pos + 1) >= rc);
    r.gradient = grad_on ? GRAD_W'({1'b0, prob} - {1'b0, lab}) : '0;
    r.gradient_valid = grad_on;
    r.row_loss = row_end ? LOSS_W'(loss_sum) : '0;
    r.loss_valid = row_end;
    r.batch_done = batch_end;
    if (grad_on || row_end) loss_grad_q.push_back(r);
    if (row_end) begin
      class_pos = 0;
      loss_sum = 0;
      row_pos = batch_end ? 0 : row_pos + 1;
    end else begin
      class_pos++;
    end
  endtask

  always @(posedge clk) begin
    ce_result_t got;
    ce_result_t want;
    if (!rst_n) begin
      class_cfg <= CLASS_COUNT_RST;
      row_cfg <= ROW_COUNT_RST;
      grad_on <= 1'b1;
      class_pos = 0;
      row_pos = 0;
      loss_sum = 0;
      loss_grad_q.delete();
      fail_count <= 0;
      pending_results <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_CLASS_COUNT: class_cfg <= cfg_ch.data[CC_W-1:0];
          REG_ROW_COUNT:   row_cfg <= cfg_ch.data[RC_W-1:0];
          REG_EMIT_GRAD:   grad_on <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_element(in_ch.probability, in_ch.label);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.gradient, out_ch.gradient_valid, out_ch.row_loss,
                out_ch.loss_valid, out_ch.batch_done};
        if (loss_grad_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = loss_grad_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("result mismatch: expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_results <= loss_grad_q.size();
    end
  end
endmodule

### sim/cross_entropy_loss_and_grad_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cross_entropy_loss_and_grad_tb
// Drives element and register traffic into the cross-entropy block under
// varying idle patterns and a long output stall; the checker scores results.
// ---------------------------------------------------------------------------
module cross_entropy_loss_and_grad_tb;
  import cel_pkg::*;

  localparam logic [VAL_W-1:0] ONE_P = VAL_W'(ONE_FIX);
  localparam logic [VAL_W-1:0] TOP_P = '1;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   in_idle_pct;
  int   out_idle_pct;
  int   elems_sent;
  int   stall_left;
  logic stall_done;

  cel_in_if  in_ch ();
  cel_out_if out_ch ();
  cel_cfg_if cfg_ch ();

  cross_entropy_loss_and_grad uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  cross_entropy_loss_and_grad_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("cross_entropy_loss_and_grad regression: fail");
    $finish;
  end

  // hold off the receiver for a long stretch once, while elements keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!stall_done && elems_sent >= 200) begin
      stall_done <= 1'b1;
      stall_left <= 600;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic send_beat(logic [VAL_W-1:0] prob, logic [VAL_W-1:0] lab);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.probability <= prob;
    in_ch.label <= lab;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    elems_sent++;
  endtask

  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_regs(int unsigned cc, int unsigned rc, int unsigned eg);
    drain_block();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_CLASS_COUNT;
    cfg_ch.data <= cc;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_ROW_COUNT;
    cfg_ch.data <= rc;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_EMIT_GRAD;
    cfg_ch.data <= eg;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly in-range probabilities with one-hot, soft or zero labels, some raw noise
  task automatic send_random(int n);
    logic [VAL_W-1:0] prob;
    logic [VAL_W-1:0] lab;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      prob = VAL_W'($urandom_range(0, ONE_FIX));
      case ($urandom_range(0, 3))
        0: lab = ONE_P;
        1: lab = VAL_W'($urandom_range(0, ONE_FIX));
        default: lab = '0;
      endcase
      if (kind == 0) begin
        prob = VAL_W'($urandom);
        lab = VAL_W'($urandom);
      end else if (kind == 1) begin
        prob = '0;
      end else if (kind == 2) begin
        prob = VAL_W'($urandom_range(0, 40));
      end
      send_beat(prob, lab);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.probability = '0;
    in_ch.label = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CLASS_COUNT;
    cfg_ch.data = '0;
    elems_sent = 0;
    in_idle_pct = 11;
    out_idle_pct = 81;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat('0, ONE_P);
    send_beat('0, TOP_P);
    send_beat(ONE_P, ONE_P);
    send_beat(TOP_P, ONE_P);
    send_beat(TOP_P, '0);
    send_beat(VAL_W'(1), ONE_P);
    send_beat(VAL_W'(EPS_VAL) - 1'b1, ONE_P);
    send_beat(VAL_W'(EPS_VAL), TOP_P);
    send_beat(ONE_P - 1'b1, ONE_P);
    send_beat(ONE_P >> 1, ONE_P >> 1);
    send_beat('0, '0);
    send_beat(ONE_P, '0);
    send_beat(VAL_W'(25'h0AAAAAA), VAL_W'(25'h1555555));
    send_beat(VAL_W'(25'h1555555), VAL_W'(25'h0AAAAAA));
    send_beat(VAL_W'(3), TOP_P);
    send_beat(ONE_P >> 3, ONE_P);
    send_beat(ONE_P >> 20, ONE_P);
    send_beat('0, TOP_P);
    send_beat(VAL_W'(7), VAL_W'(12345));
    send_beat(ONE_P, TOP_P);

    set_regs(1, 0, 1);
    send_random(40);
    set_regs(3, 2, 0);
    send_random(60);
    in_idle_pct = 81;
    out_idle_pct = 11;
    set_regs(5, 4, 1);
    send_random(90);
    set_regs(32'h0000_07FF, 32'h0001_FFFF, 1);
    send_random(30);
    set_regs(4, 1, 1);
    send_random(40);
    set_regs(0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_random(20);
    in_idle_pct = 0;
    out_idle_pct = 0;
    set_regs(64, 1, 0);
    for (int i = 0; i < 64; i++) send_beat('0, TOP_P);
    set_regs(7, 3, 1);
    send_random(100);

    drain_block();
    if (fail_count == 0) begin
      $display("cross_entropy_loss_and_grad regression: pass");
    end else begin
      $display("cross_entropy_loss_and_grad regression: fail");
    end
    $finish;
  end
endmodule
